// File: rtl/core/rcfe_pkg.sv
`timescale 1ns / 1ps

package rcfe_pkg;

    localparam int ADDR_W  = 7;
    localparam int CODE_W  = 8;
    localparam int DATA_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int S_TDATA_W = 24;

    localparam logic [BYTE_W-1:0] FRAME_SOH  = 8'h01;
    localparam logic [BYTE_W-1:0] FRAME_STX  = 8'h02;
    localparam logic [BYTE_W-1:0] FRAME_ETX  = 8'h03;
    localparam logic [BYTE_W-1:0] FRAME_CMD  = 8'h53;
    localparam logic [BYTE_W-1:0] CHECK_OR   = 8'h20;
    localparam logic [CODE_W-1:0] RAW_CODE   = 8'hFF;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_HEXA = 8'h37;

    typedef enum logic [3:0] {
        PH_SOH,
        PH_CMD,
        PH_ADDR_HI,
        PH_ADDR_LO,
        PH_CODE_HI,
        PH_CODE_LO,
        PH_STX,
        PH_DATA,
        PH_ETX,
        PH_SUM
    } rcfe_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]      addr_hi;
        logic [BYTE_W-1:0]      addr_lo;
        logic [BYTE_W-1:0]      code_hi;
        logic [BYTE_W-1:0]      code_lo;
        logic [2:0][BYTE_W-1:0] dat;
        logic [1:0]             dlen;
    } rcfe_desc_t;

    function automatic logic [4:0] div10(input logic [7:0] x);
        logic [15:0] p;
        p = {8'd0, x} * 16'd205;
        return p[15:11];
    endfunction

    function automatic logic [1:0] div100(input logic [7:0] x);
        logic [15:0] p;
        p = {8'd0, x} * 16'd41;
        return p[13:12];
    endfunction

    function automatic logic [3:0] rem10(input logic [7:0] x, input logic [4:0] q);
        logic [7:0] p;
        p = {3'd0, q} * 8'd10;
        return 4'(x - p);
    endfunction

    function automatic logic [3:0] fold10(input logic [4:0] q);
        logic [4:0] r;
        if (q >= 5'd20)
            r = q - 5'd20;
        else if (q >= 5'd10)
            r = q - 5'd10;
        else
            r = q;
        return r[3:0];
    endfunction

    function automatic logic [BYTE_W-1:0] dec_char(input logic [3:0] d);
        return ASCII_ZERO + {4'd0, d};
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] d);
        logic [BYTE_W-1:0] c;
        if (d < 4'd10)
            c = ASCII_ZERO + {4'd0, d};
        else
            c = ASCII_HEXA + {4'd0, d};
        return c;
    endfunction

endpackage

// File: rtl/core/reader_command_frame_encoder_unit.sv
`timescale 1ns / 1ps
// Each request is written into the two-entry request queue, and each frame byte is then
// registered from the queue head into the output register. The single-byte output port
// carries one frame byte per cycle while m_tready is high, 10 to 12 bytes per request; the
// queue holds the next request while a frame goes out, and s_tready drops while both entries are full.
// Reset (rst_n low, asynchronous) empties the request queue, returns the byte
// sequencer to the frame start and drops m_tvalid.

module reader_command_frame_encoder_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // device_address[6:0], function_code[14:7], data_value[22:15], zero[23]
    input  logic [rcfe_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // frame_byte[7:0]
    output logic [rcfe_pkg::BYTE_W-1:0]    m_tdata,
    output logic                           m_tlast
);

    rcfe_pkg::rcfe_desc_t front_desc;
    rcfe_pkg::rcfe_desc_t head_desc;
    logic                 head_valid;
    logic                 head_pop;

    rcfe_front u_front
    (
        .device_address (s_tdata[6:0]),
        .function_code  (s_tdata[14:7]),
        .data_value     (s_tdata[22:15]),
        .desc           (front_desc)
    );

    rcfe_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_desc   (front_desc),
        .out_valid (head_valid),
        .out_ready (head_pop),
        .out_desc  (head_desc)
    );

    rcfe_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (head_valid),
        .desc_pop   (head_pop),
        .desc       (head_desc),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// File: rtl/core/rcfe_front.sv
`timescale 1ns / 1ps

module rcfe_front
(
    input  logic [rcfe_pkg::ADDR_W-1:0] device_address,
    input  logic [rcfe_pkg::CODE_W-1:0] function_code,
    input  logic [rcfe_pkg::DATA_W-1:0] data_value,
    output rcfe_pkg::rcfe_desc_t        desc
);

    logic [7:0] addr8;
    logic [4:0] addr_q;
    logic [3:0] addr_ones;
    logic [4:0] data_q;
    logic [1:0] data_h;
    logic [3:0] data_ones;
    logic [3:0] data_tens;

    always_comb
    begin
        addr8     = {1'b0, device_address};
        addr_q    = rcfe_pkg::div10(addr8);
        addr_ones = rcfe_pkg::rem10(addr8, addr_q);
        data_q    = rcfe_pkg::div10(data_value);
        data_h    = rcfe_pkg::div100(data_value);
        data_ones = rcfe_pkg::rem10(data_value, data_q);
        data_tens = rcfe_pkg::fold10(data_q);

        desc.addr_hi = rcfe_pkg::dec_char(rcfe_pkg::fold10(addr_q));
        desc.addr_lo = rcfe_pkg::dec_char(addr_ones);
        desc.code_hi = rcfe_pkg::hex_char(function_code[7:4]);
        desc.code_lo = rcfe_pkg::hex_char(function_code[3:0]);
        desc.dat     = '0;

        priority if (function_code == rcfe_pkg::RAW_CODE)
        begin
            desc.dat[0] = data_value;
            desc.dlen   = 2'd1;
        end
        else if (data_value >= 8'd100)
        begin
            desc.dat[0] = rcfe_pkg::dec_char({2'd0, data_h});
            desc.dat[1] = rcfe_pkg::dec_char(data_tens);
            desc.dat[2] = rcfe_pkg::dec_char(data_ones);
            desc.dlen   = 2'd3;
        end
        else if (data_value >= 8'd10)
        begin
            desc.dat[0] = rcfe_pkg::dec_char(data_tens);
            desc.dat[1] = rcfe_pkg::dec_char(data_ones);
            desc.dlen   = 2'd2;
        end
        else
        begin
            desc.dat[0] = rcfe_pkg::dec_char(data_ones);
            desc.dlen   = 2'd1;
        end
    end

endmodule

// File: rtl/core/rcfe_queue.sv
`timescale 1ns / 1ps

module rcfe_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rcfe_pkg::rcfe_desc_t in_desc,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rcfe_pkg::rcfe_desc_t out_desc
);

    rcfe_pkg::rcfe_desc_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    always_comb
    begin
        in_ready    = (count_reg != 2'd2);
        out_valid   = (count_reg != 2'd0);
        out_desc    = slot_reg[rd_ptr_reg];
        push        = in_valid && in_ready;
        pop         = out_valid && out_ready;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_desc;
    end

endmodule

// File: rtl/core/rcfe_back.sv
`timescale 1ns / 1ps

module rcfe_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        desc_valid,
    output logic                        desc_pop,
    input  rcfe_pkg::rcfe_desc_t        desc,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rcfe_pkg::BYTE_W-1:0] m_tdata,
    output logic                        m_tlast
);

    rcfe_pkg::rcfe_phase_t       phase_reg;
    rcfe_pkg::rcfe_phase_t       phase_next;
    logic [1:0]                  didx_reg;
    logic [1:0]                  didx_next;
    logic [rcfe_pkg::BYTE_W-1:0] sum_reg;
    logic [rcfe_pkg::BYTE_W-1:0] sum_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [rcfe_pkg::BYTE_W-1:0] out_byte_reg;
    logic [rcfe_pkg::BYTE_W-1:0] out_byte_next;
    logic                        out_last_reg;
    logic                        out_last_next;
    logic                        emit;
    logic [rcfe_pkg::BYTE_W-1:0] cur_byte;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        emit       = (!out_valid_reg || m_tready) && desc_valid;
        phase_next = phase_reg;
        didx_next  = didx_reg;
        desc_pop   = 1'b0;
        cur_byte   = rcfe_pkg::FRAME_SOH;

        unique case (phase_reg)
            rcfe_pkg::PH_SOH:
            begin
                cur_byte   = rcfe_pkg::FRAME_SOH;
                phase_next = rcfe_pkg::PH_CMD;
            end
            rcfe_pkg::PH_CMD:
            begin
                cur_byte   = rcfe_pkg::FRAME_CMD;
                phase_next = rcfe_pkg::PH_ADDR_HI;
            end
            rcfe_pkg::PH_ADDR_HI:
            begin
                cur_byte   = desc.addr_hi;
                phase_next = rcfe_pkg::PH_ADDR_LO;
            end
            rcfe_pkg::PH_ADDR_LO:
            begin
                cur_byte   = desc.addr_lo;
                phase_next = rcfe_pkg::PH_CODE_HI;
            end
            rcfe_pkg::PH_CODE_HI:
            begin
                cur_byte   = desc.code_hi;
                phase_next = rcfe_pkg::PH_CODE_LO;
            end
            rcfe_pkg::PH_CODE_LO:
            begin
                cur_byte   = desc.code_lo;
                phase_next = rcfe_pkg::PH_STX;
            end
            rcfe_pkg::PH_STX:
            begin
                cur_byte   = rcfe_pkg::FRAME_STX;
                phase_next = rcfe_pkg::PH_DATA;
                didx_next  = 2'd0;
            end
            rcfe_pkg::PH_DATA:
            begin
                cur_byte = desc.dat[didx_reg];
                if (didx_reg == desc.dlen - 2'd1)
                begin
                    phase_next = rcfe_pkg::PH_ETX;
                    didx_next  = 2'd0;
                end
                else
                    didx_next = didx_reg + 2'd1;
            end
            rcfe_pkg::PH_ETX:
            begin
                cur_byte   = rcfe_pkg::FRAME_ETX;
                phase_next = rcfe_pkg::PH_SUM;
            end
            rcfe_pkg::PH_SUM:
            begin
                cur_byte   = sum_reg | rcfe_pkg::CHECK_OR;
                phase_next = rcfe_pkg::PH_SOH;
                desc_pop   = emit;
            end
            default:
            begin
                cur_byte   = rcfe_pkg::FRAME_SOH;
                phase_next = rcfe_pkg::PH_SOH;
            end
        endcase

        if (!emit)
        begin
            phase_next = phase_reg;
            didx_next  = didx_reg;
        end

        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            sum_next       = (phase_reg == rcfe_pkg::PH_SOH) ? cur_byte : (sum_reg ^ cur_byte);
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            out_last_next  = (phase_reg == rcfe_pkg::PH_SUM);
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= rcfe_pkg::PH_SOH;
            didx_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            didx_reg      <= didx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule
